>>> rtl/gsph_pkg.sv
// Package: constants, types and command/status structs of the grid-sampled histogram unit.
package gsph_pkg;
  localparam int GRID_MAX    = 4;
  localparam int SAMPLES_MAX = 32;
  localparam int DIM_MAX     = 4096;
  localparam int CHANNELS    = 3;
  localparam int BUCKETS     = 4;
  localparam int VALUE_SHIFT = 6;
  localparam int CNT_W       = 11;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 13;
  localparam int GS_W        = 8;
  localparam int CELLS       = GRID_MAX * GRID_MAX * CHANNELS;
  localparam int ADDR_W      = $clog2(CELLS);

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_GRID    = 2'd2;
  localparam logic [1:0] REG_SAMPLES = 2'd3;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
  } pix_t;

  typedef struct packed {
    logic [1:0]       cell_row;
    logic [1:0]       cell_col;
    logic [1:0]       channel;
    logic [CNT_W-1:0] bucket0_count;
    logic [CNT_W-1:0] bucket1_count;
    logic [CNT_W-1:0] bucket2_count;
    logic [CNT_W-1:0] bucket3_count;
    logic             geometry_error;
    logic             last_result;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic pix_load;   // latch pixel
    logic geo_start;  // begin frame setup
    logic div_step;   // one divider step
    logic geo_finish; // compute first sample positions
    logic clr;        // clear one store word
    logic sample;     // evaluate and count latched pixel
    logic emit_rd;    // read one result
    logic emit_adv;   // advance emit indices
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_start;
    logic div_done;
    logic clr_done;
    logic frame_end;
    logic emit_last;
  } sts_t;
endpackage

>>> rtl/gsph_stream_if.sv
// Interface: valid/ready stream channel carrying a typed payload.
interface gsph_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gsph_datapath.sv
// Datapath: geometry setup, sample tracking, divider and histogram store.
module gsph_datapath import gsph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  input  pix_t             pix_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output res_t             res_o
);
  logic [DIM_W-1:0] width_q, height_q;
  logic [2:0] grid_cfg_q;
  logic [5:0] samp_cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= DIM_W'(1920); height_q <= DIM_W'(1080);
      grid_cfg_q <= 3'd3; samp_cfg_q <= 6'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:   width_q <= cfg_data_i;
        REG_HEIGHT:  height_q <= cfg_data_i;
        REG_GRID:    grid_cfg_q <= cfg_data_i[2:0];
        REG_SAMPLES: samp_cfg_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  pix_t pix_q;
  always_ff @(posedge clk_i) if (cmd_i.pix_load) pix_q <= pix_i;

  // frame geometry
  logic [DIM_W-1:0] fw_q, fh_q;
  logic [2:0] g_q;
  logic [5:0] s_q;
  logic [GS_W-1:0] gs_q;
  logic err_q;
  logic [DIM_W-1:0] w_sat, h_sat;
  logic [2:0] g_sat;
  logic [5:0] s_sat;
  logic [GS_W-1:0] gs_sat;
  always_comb begin
    w_sat = (width_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : width_q;
    h_sat = (height_q > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : height_q;
    g_sat = (grid_cfg_q == 3'd0) ? 3'd1 :
            (grid_cfg_q > 3'(GRID_MAX)) ? 3'(GRID_MAX) : grid_cfg_q;
    s_sat = (samp_cfg_q == 6'd0) ? 6'd1 :
            (samp_cfg_q > 6'(SAMPLES_MAX)) ? 6'(SAMPLES_MAX) : samp_cfg_q;
    gs_sat = GS_W'(g_sat) * GS_W'(s_sat);
  end

  // restoring divider: two divisions (w/gs, h/gs) at once, sharing one step counter
  logic [DIM_W-1:0] qx_q, qy_q, rx_q, ry_q;
  logic [3:0] dcnt_q;
  logic [DIM_W:0] rx_t, ry_t;
  always_comb begin
    rx_t = {rx_q, qx_q[DIM_W-1]};
    ry_t = {ry_q, qy_q[DIM_W-1]};
  end

  logic [POS_W-1:0] first_x_q, nx_q, ny_q;
  logic [DIM_W-1:0] col_q, row_q;
  logic [GS_W-1:0] sci_q, sri_q;
  logic [5:0] scell_x_q, scell_y_q;
  logic [1:0] cc_q, cr_q;

  // sample evaluation
  logic row_hit, col_hit, line_end;
  always_comb begin
    row_hit = !err_q && (sri_q < gs_q) && (row_q == ny_q);
    col_hit = row_hit && (sci_q < gs_q) && (col_q == nx_q);
    line_end = (DIM_W+1)'(col_q) + 1'b1 >= (DIM_W+1)'(fw_q);
  end

  // store: one word per (row, col, channel), four counts packed
  logic [4*CNT_W-1:0] mem [CELLS];
  logic [ADDR_W-1:0] clr_addr_q, rd_addr;
  logic [4*CNT_W-1:0] rd_q;
  logic [ADDR_W-1:0] ch_base;
  logic [ADDR_W-1:0] smp_base_q;
  logic [1:0] sm_q; // stage: 0 idle,1 read,2 write (per channel)
  logic [1:0] ch_q;
  logic [ADDR_W-1:0] inc_addr_q;
  logic [1:0] inc_b_q;
  logic [1:0] ech_q, er_q, ec_q;
  logic busy_q;
  logic [2:0][1:0] bsel_q;

  always_comb begin
    ch_base = ADDR_W'((cr_q * GRID_MAX + cc_q) * CHANNELS);
    rd_addr = cmd_i.emit_rd ? ADDR_W'((er_q * GRID_MAX + ec_q) * CHANNELS + ech_q)
                            : ADDR_W'(smp_base_q + ch_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd || (sm_q == 2'd1)) rd_q <= mem[rd_addr];
    if (cmd_i.clr) mem[clr_addr_q] <= '0;
    else if (sm_q == 2'd2) begin
      mem[inc_addr_q][inc_b_q*CNT_W +: CNT_W] <= rd_q[inc_b_q*CNT_W +: CNT_W] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0; clr_addr_q <= '0; sm_q <= '0; ch_q <= '0; busy_q <= 1'b0;
      err_q <= 1'b0; er_q <= '0; ec_q <= '0; ech_q <= '0;
      fw_q <= '0; fh_q <= '0; g_q <= '0; s_q <= '0; gs_q <= '0;
      col_q <= '0; row_q <= '0; sci_q <= '0; sri_q <= '0; nx_q <= '0; ny_q <= '0;
      scell_x_q <= '0; scell_y_q <= '0; cc_q <= '0; cr_q <= '0; first_x_q <= '0;
      qx_q <= '0; qy_q <= '0; rx_q <= '0; ry_q <= '0;
      smp_base_q <= '0; inc_addr_q <= '0; inc_b_q <= '0; bsel_q <= '0;
    end else begin
      if (cmd_i.geo_start) begin
        fw_q <= w_sat; fh_q <= h_sat; g_q <= g_sat; s_q <= s_sat; gs_q <= gs_sat;
        err_q <= (grid_cfg_q == 3'd0) || (samp_cfg_q == 6'd0) ||
                 (w_sat < DIM_W'(gs_sat)) || (h_sat < DIM_W'(gs_sat));
        qx_q <= w_sat; qy_q <= h_sat; rx_q <= '0; ry_q <= '0; dcnt_q <= '0;
        clr_addr_q <= '0; er_q <= '0; ec_q <= '0; ech_q <= '0;
        col_q <= '0; row_q <= '0; sci_q <= '0; sri_q <= '0;
        scell_x_q <= '0; scell_y_q <= '0; cc_q <= '0; cr_q <= '0;
        sm_q <= '0; busy_q <= 1'b0;
      end
      if (cmd_i.div_step) begin
        if (rx_t >= (DIM_W+1)'(gs_q)) begin
          rx_q <= DIM_W'(rx_t - (DIM_W+1)'(gs_q)); qx_q <= {qx_q[DIM_W-2:0], 1'b1};
        end else begin
          rx_q <= DIM_W'(rx_t); qx_q <= {qx_q[DIM_W-2:0], 1'b0};
        end
        if (ry_t >= (DIM_W+1)'(gs_q)) begin
          ry_q <= DIM_W'(ry_t - (DIM_W+1)'(gs_q)); qy_q <= {qy_q[DIM_W-2:0], 1'b1};
        end else begin
          ry_q <= DIM_W'(ry_t); qy_q <= {qy_q[DIM_W-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.clr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.geo_finish) begin
        // remainder r = w - gs*pitch; first x = pitch/2 + r/2, first y one less (floor 0)
        if (err_q) begin
          first_x_q <= '0; nx_q <= '0; ny_q <= '0;
        end else begin
          first_x_q <= (qx_q >> 1) + (rx_q >> 1);
          nx_q <= (qx_q >> 1) + (rx_q >> 1);
          ny_q <= ((qy_q >> 1) + (ry_q >> 1) == '0) ? '0 : (qy_q >> 1) + (ry_q >> 1) - 1'b1;
        end
      end
      // store update pipeline: read then write, one channel at a time
      unique case (sm_q)
        2'd1: begin sm_q <= 2'd2; end
        2'd2: begin
          if (ch_q == 2'(CHANNELS-1)) begin sm_q <= 2'd0; busy_q <= 1'b0; end
          else begin ch_q <= ch_q + 1'b1; sm_q <= 2'd1; end
        end
        default: ;
      endcase
      if (sm_q == 2'd1) begin
        inc_addr_q <= ADDR_W'(smp_base_q + ch_q);
        inc_b_q <= bsel_q[ch_q];
      end
      if (cmd_i.sample) begin
        if (col_hit) begin
          sm_q <= 2'd1; ch_q <= '0; busy_q <= 1'b1;
          smp_base_q <= ch_base;
          bsel_q <= {pix_q.ch2[7:6], pix_q.ch1[7:6], pix_q.ch0[7:6]};
        end
        if (line_end) begin
          if (row_hit) begin
            sri_q <= sri_q + 1'b1;
            ny_q <= ny_q + qy_q;
            if (scell_y_q + 1'b1 == s_q) begin scell_y_q <= '0; cr_q <= cr_q + 1'b1; end
            else scell_y_q <= scell_y_q + 1'b1;
          end
          sci_q <= '0; nx_q <= first_x_q; scell_x_q <= '0; cc_q <= '0;
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          if (col_hit) begin
            sci_q <= sci_q + 1'b1;
            nx_q <= nx_q + qx_q;
            if (scell_x_q + 1'b1 == s_q) begin scell_x_q <= '0; cc_q <= cc_q + 1'b1; end
            else scell_x_q <= scell_x_q + 1'b1;
          end
          col_q <= col_q + 1'b1;
        end
      end
      if (cmd_i.emit_adv) begin
        if (ech_q == 2'(CHANNELS-1)) begin
          ech_q <= '0;
          if (ec_q == 2'(g_q - 1'b1)) begin ec_q <= '0; er_q <= er_q + 1'b1; end
          else ec_q <= ec_q + 1'b1;
        end else ech_q <= ech_q + 1'b1;
      end
    end
  end

  // hold the indices of the item being emitted
  logic [1:0] out_row_q, out_col_q, out_ch_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_rd) {out_row_q, out_col_q, out_ch_q} <= {er_q, ec_q, ech_q};
  end

  always_comb begin
    sts_o.frame_start = pix_q.frame_start;
    sts_o.div_done = (dcnt_q == 4'(DIM_W));
    sts_o.clr_done = (clr_addr_q == ADDR_W'(CELLS-1));
    sts_o.frame_end = line_end && ((DIM_W+1)'(row_q) + 1'b1 >= (DIM_W+1)'(fh_q)) && !busy_q;
    sts_o.emit_last = (ech_q == 2'(CHANNELS-1)) && (ec_q == 2'(g_q - 1'b1)) &&
                      (er_q == 2'(g_q - 1'b1));
    res_o.cell_row = out_row_q;
    res_o.cell_col = out_col_q;
    res_o.channel = out_ch_q;
    res_o.bucket0_count = err_q ? '0 : rd_q[0*CNT_W +: CNT_W];
    res_o.bucket1_count = err_q ? '0 : rd_q[1*CNT_W +: CNT_W];
    res_o.bucket2_count = err_q ? '0 : rd_q[2*CNT_W +: CNT_W];
    res_o.bucket3_count = err_q ? '0 : rd_q[3*CNT_W +: CNT_W];
    res_o.geometry_error = err_q;
    res_o.last_result = 1'b0;
  end
endmodule

>>> rtl/gsph_controller.sv
// Controller: frame sequencing, per-pixel handshake and result emission.
module gsph_controller import gsph_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output logic out_last_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_DIV = 4'd2;
  localparam logic [3:0] S_FIN = 4'd3;
  localparam logic [3:0] S_CLR = 4'd4;
  localparam logic [3:0] S_SAMPLE = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_RD = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state_q, state_d;
  logic active_q, active_d;
  logic [2:0] wcnt_q, wcnt_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; active_q <= 1'b0; wcnt_q <= '0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; active_q <= active_d; wcnt_q <= wcnt_d; last_q <= last_d;
    end
  end

  always_comb begin
    state_d = state_q; active_d = active_q; wcnt_d = wcnt_q; last_d = last_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    out_last_o = last_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin cmd_o.pix_load = 1'b1; state_d = S_DECIDE; end
      end
      S_DECIDE: begin
        if (sts_i.frame_start) begin cmd_o.geo_start = 1'b1; state_d = S_DIV; end
        else if (active_q) state_d = S_SAMPLE;
        else state_d = S_IDLE;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_FIN;
        else cmd_o.div_step = 1'b1;
      end
      S_FIN: begin cmd_o.geo_finish = 1'b1; state_d = S_CLR; end
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) begin active_d = 1'b1; state_d = S_SAMPLE; end
      end
      S_SAMPLE: begin
        cmd_o.sample = 1'b1; wcnt_d = 3'd7; state_d = S_WAIT;
        if (sts_i.frame_end) active_d = 1'b0;
      end
      S_WAIT: begin
        wcnt_d = wcnt_q - 1'b1;
        if (wcnt_q == 3'd0) state_d = active_q ? S_IDLE : S_RD;
      end
      S_RD: begin
        cmd_o.emit_rd = 1'b1; last_d = sts_i.emit_last; state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_q) state_d = S_IDLE;
          else begin cmd_o.emit_adv = 1'b1; state_d = S_RD; end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

>>> rtl/grid_sampled_pixel_histogram_unit.sv
// Top level: grid-sampled coarse color histogram unit.
// Input channel pix carries one pixel item: frame_start and three byte values.
// Output channel res carries one histogram item per grid cell and channel,
// in row, column, channel order, last_result set on the final item.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
// it is latched into the frame geometry on each frame_start pixel.
// A pixel in a frame is latched, then decided on and evaluated, then a wait
// covers the three-channel read-modify-write of the store; the next pixel is
// accepted only after that wait. A pixel outside a frame is latched, then dropped.
// A frame_start pixel first runs the pitch divider, the first-position setup
// and a clear of every store word, and is evaluated after them.
// After the last pixel of a frame is evaluated and its wait ends, each result
// is read from the store and held valid until the receiver takes it; results
// are delivered one at a time, a stalled receiver holds the current item and
// no pixel is accepted until all results of the frame are delivered.
// Reset restores the default geometry (1920x1080, grid 3, 10 samples) and
// leaves no frame active; pixels before the first frame_start are dropped.
module grid_sampled_pixel_histogram_unit import gsph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  gsph_stream_if.sink      pix,
  gsph_stream_if.source    res
);
  cmd_t cmd;
  sts_t sts;
  res_t dp_res;
  logic last;

  gsph_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(pix.valid), .in_ready_o(pix.ready),
    .out_ready_i(res.ready), .out_valid_o(res.valid), .out_last_o(last),
    .sts_i(sts), .cmd_o(cmd)
  );

  gsph_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i(pix.data), .cmd_i(cmd), .sts_o(sts), .res_o(dp_res)
  );

  always_comb begin
    res.data = dp_res;
    res.data.last_result = last;
  end
endmodule

>>> bench/tb_grid_sampled_pixel_histogram_unit.sv
// Testbench: grid-sampled histogram unit checked against a predictor of per-cell bucket counts.
`timescale 1ns / 1ps

module tb_grid_sampled_pixel_histogram_unit;
  import gsph_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int FRAME_TARGET = 100;

  typedef struct {
    bit       fs;
    bit [7:0] c0;
    bit [7:0] c1;
    bit [7:0] c2;
  } pix_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_WIDTH;
  logic [DIM_W-1:0] cfg_data_i = '0;

  gsph_stream_if #(.T(pix_t)) pix_if ();
  gsph_stream_if #(.T(res_t)) res_if ();

  grid_sampled_pixel_histogram_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix(pix_if),
    .res(res_if)
  );

  // predictor state
  int unsigned reg_w = 1920, reg_h = 1080, reg_g = 3, reg_s = 10;
  int unsigned col_pos, row_pos, step_x, step_y, next_x, next_y, col_idx, row_idx;
  int unsigned fr_w, fr_h, fr_g, fr_s, fr_x0;
  bit fr_active, fr_err;
  logic [CNT_W-1:0] bucket_cnt [GRID_MAX][GRID_MAX][CHANNELS][BUCKETS];

  res_t hist_q[$];
  int mismatches = 0;
  bit failed = 1'b0;
  int src_idle_pct = 26;
  int snk_idle_pct = 48;
  int stall_cycles = 0;
  int frame_pixels = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_buckets();
    foreach (bucket_cnt[r, c, ch, b]) bucket_cnt[r][c][ch][b] = '0;
  endfunction

  function automatic void open_frame();
    int unsigned w, h, g, s, gs, top;
    w = (reg_w > DIM_MAX) ? DIM_MAX : reg_w;
    h = (reg_h > DIM_MAX) ? DIM_MAX : reg_h;
    g = reg_g;
    s = reg_s;
    fr_err = (g == 0) || (s == 0);
    if (g == 0) g = 1;
    if (g > GRID_MAX) g = GRID_MAX;
    if (s == 0) s = 1;
    if (s > SAMPLES_MAX) s = SAMPLES_MAX;
    gs = g * s;
    if (w < gs || h < gs) fr_err = 1'b1;
    fr_w = w;
    fr_h = h;
    fr_g = g;
    fr_s = s;
    clear_buckets();
    step_x = w / gs;
    step_y = h / gs;
    fr_x0 = 0;
    top = 0;
    if (!fr_err) begin
      fr_x0 = step_x / 2 + (w - gs * step_x) / 2;
      top = step_y / 2 + (h - gs * step_y) / 2;
      if (top > 0) top -= 1;
    end
    next_x = fr_x0;
    next_y = top;
    col_idx = 0;
    row_idx = 0;
    col_pos = 0;
    row_pos = 0;
    fr_active = 1'b1;
  endfunction

  function automatic void push_histograms();
    res_t h;
    for (int r = 0; r < fr_g; r++)
      for (int c = 0; c < fr_g; c++)
        for (int ch = 0; ch < CHANNELS; ch++) begin
          h.cell_row = r[1:0];
          h.cell_col = c[1:0];
          h.channel = ch[1:0];
          h.bucket0_count = fr_err ? '0 : bucket_cnt[r][c][ch][0];
          h.bucket1_count = fr_err ? '0 : bucket_cnt[r][c][ch][1];
          h.bucket2_count = fr_err ? '0 : bucket_cnt[r][c][ch][2];
          h.bucket3_count = fr_err ? '0 : bucket_cnt[r][c][ch][3];
          h.geometry_error = fr_err;
          h.last_result = (r == fr_g - 1) && (c == fr_g - 1) && (ch == CHANNELS - 1);
          hist_q.push_back(h);
        end
  endfunction

  function automatic void count_pixel(pix_t p);
    int unsigned gs, cr, cc;
    bit row_hit;
    logic [7:0] v [CHANNELS];
    v[0] = p.ch0;
    v[1] = p.ch1;
    v[2] = p.ch2;
    if (p.frame_start) open_frame();
    if (!fr_active) return;
    gs = fr_g * fr_s;
    row_hit = !fr_err && row_idx < gs && row_pos == next_y;
    if (row_hit && col_idx < gs && col_pos == next_x) begin
      cr = row_idx / fr_s;
      cc = col_idx / fr_s;
      for (int ch = 0; ch < CHANNELS; ch++)
        if (cr < GRID_MAX && cc < GRID_MAX)
          bucket_cnt[cr][cc][ch][v[ch][7:6]] += 1'b1;
      col_idx++;
      next_x += step_x;
    end
    if (col_pos + 1 >= fr_w) begin
      if (row_hit) begin
        row_idx++;
        next_y += step_y;
      end
      col_idx = 0;
      next_x = fr_x0;
      col_pos = 0;
      if (row_pos + 1 >= fr_h) begin
        fr_active = 1'b0;
        row_pos = 0;
        push_histograms();
        return;
      end
      row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  task automatic send_pixel(bit fs, bit [7:0] c0, bit [7:0] c1, bit [7:0] c2);
    pix_t p;
    p = '{frame_start: fs, ch0: c0, ch1: c1, ch2: c2};
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.data <= p;
    do @(posedge clk_i); while (!pix_if.ready);
    count_pixel(p);
  endtask

  task automatic send_random(bit fs);
    send_pixel(fs, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic settle();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    wait (hist_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned g, int unsigned s);
    int unsigned vals [4];
    logic [1:0] idx [4];
    vals = '{w, h, g, s};
    idx = '{REG_WIDTH, REG_HEIGHT, REG_GRID, REG_SAMPLES};
    settle();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i][DIM_W-1:0];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (1'b1)
      1'b1: begin
        reg_w = w & 13'h1FFF;
        reg_h = h & 13'h1FFF;
        reg_g = g & 3'h7;
        reg_s = s & 6'h3F;
      end
    endcase
  endtask

  task automatic send_frame(int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) begin
      send_random(i == 0);
      frame_pixels++;
    end
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[grid_sampled_pixel_histogram_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    res_t exp_h;
    if (res_if.valid && res_if.ready) begin
      if (hist_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected histogram item: %p", res_if.data);
      end else begin
        exp_h = hist_q.pop_front();
        if (res_if.data !== exp_h) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("histogram mismatch: expected %p, got %p", exp_h, res_if.data);
        end
      end
    end
  end

  pix_row_t directed [] = '{
    '{1'b0, 8'd12, 8'd200, 8'd90},
    '{1'b1, 8'd0, 8'd255, 8'd63},
    '{1'b0, 8'd64, 8'd127, 8'd128},
    '{1'b0, 8'd191, 8'd192, 8'd255},
    '{1'b0, 8'd255, 8'd0, 8'd64},
    '{1'b0, 8'd128, 8'd191, 8'd127},
    '{1'b0, 8'd63, 8'd192, 8'd0},
    '{1'b1, 8'd255, 8'd255, 8'd255},
    '{1'b0, 8'd0, 8'd0, 8'd0},
    '{1'b1, 8'd170, 8'd85, 8'd15},
    '{1'b0, 8'd240, 8'd1, 8'd100},
    '{1'b0, 8'd33, 8'd66, 8'd99},
    '{1'b0, 8'd129, 8'd193, 8'd65},
    '{1'b0, 8'd254, 8'd2, 8'd190},
    '{1'b0, 8'd7, 8'd250, 8'd126},
    '{1'b0, 8'd77, 8'd77, 8'd77}
  };

  initial begin
    int unsigned w, h, g, s;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    res_if.ready = 1'b0;
    clear_buckets();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_geometry(3, 2, 1, 2);
    foreach (directed[i])
      send_pixel(directed[i].fs, directed[i].c0, directed[i].c1, directed[i].c2);
    set_geometry(3, 2, 4, 32);
    send_frame(3, 2);

    while (frame_pixels < FRAME_TARGET) begin
      if (frame_pixels < FRAME_TARGET / 3) begin
        src_idle_pct = 26;
        snk_idle_pct = 48;
      end else if (frame_pixels < 2 * FRAME_TARGET / 3) begin
        src_idle_pct = 48;
        snk_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      g = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(1, 3);
      s = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(1, 2);
      set_geometry(w, h, g, s);
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 3)) send_random(1'b0);
      if ($urandom_range(99) < 10)
        repeat ($urandom_range(1, w * h)) send_random(1'b1 && ($urandom_range(3) == 0));
      send_frame(w, h);
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 3)) send_random(1'b0);
    end

    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_geometry(4, 4, 7, 1);
    send_frame(4, 4);
    set_geometry(1, 1, 1, 63);
    send_frame(1, 1);
    set_geometry(4, 4, 4, 1);
    send_frame(4, 4);

    settle();
    if (hist_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("[grid_sampled_pixel_histogram_unit] OK");
    end else begin
      $display("[grid_sampled_pixel_histogram_unit] ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/gsph_pkg.sv
rtl/gsph_stream_if.sv
rtl/gsph_datapath.sv
rtl/gsph_controller.sv
rtl/grid_sampled_pixel_histogram_unit.sv
bench/tb_grid_sampled_pixel_histogram_unit.sv
